// ===== hw/rtl/http_request_head_tagger_core_macros.svh =====
// ----------------------------------------------------------------------------
// HTTP request head tagger - assertion macros
// Clocked, reset-qualified property checks for the tagger core.
// ----------------------------------------------------------------------------
`ifndef HTTP_REQUEST_HEAD_TAGGER_CORE_MACROS_SVH
`define HTTP_REQUEST_HEAD_TAGGER_CORE_MACROS_SVH

// Checked on every rising edge of aclk, ignored while aresetn is low
`define HRHT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Same check, also active during reset
`define HRHT_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

// ===== hw/rtl/hrht_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// HTTP request head tagger - package
// Limits, byte constants, byte class and status codes shared by the core.
// ----------------------------------------------------------------------------
package hrht_pkg;

    localparam int METHOD_LIMIT = 8;
    localparam int PATH_LIMIT   = 256;
    localparam int HEADER_LIMIT = 32;

    // field length counter: holds any path length below the limit
    localparam int FLEN_W = $clog2(PATH_LIMIT) + 1;
    // header counter: holds the limit itself
    localparam int HCNT_W = $clog2(HEADER_LIMIT + 1);

    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_COLON = 8'h3A;

    typedef enum logic [2:0] {
        CLS_METHOD  = 3'd0,
        CLS_PATH    = 3'd1,
        CLS_VERSION = 3'd2,
        CLS_NAME    = 3'd3,
        CLS_VALUE   = 3'd4,
        CLS_BODY    = 3'd5,
        CLS_SEP     = 3'd6
    } byte_class_t;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_NO_SPACE    = 3'd1,
        ST_METHOD_LONG = 3'd2,
        ST_PATH_LONG   = 3'd3,
        ST_NO_COLON    = 3'd4,
        ST_TOO_MANY    = 3'd5,
        ST_BAD_EOL     = 3'd6
    } status_t;

endpackage
`default_nettype wire

// ===== hw/rtl/http_request_head_tagger_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// HTTP request head tagger - core
// Tags each request byte by field, counts headers and reports format status.
// ----------------------------------------------------------------------------
// Output: the result of each input transfer is registered in the output register.
// Throughput: one byte per cycle; the parse state and the output register
//   update in the same edge, so a new byte is taken while a result waits
//   as long as the output register is drained in that cycle.
// Reset: aresetn (synchronous, active low) clears the parse state and the
//   output valid; the parse state also returns to reset after each last byte.
`include "http_request_head_tagger_core_macros.svh"

module http_request_head_tagger_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  wire logic        s_axis_tlast,   // last_byte
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,  // [7:0] out_byte, [12:8] header_index,
                                       // [13] field_start, [14] error_now,
                                       // [17:15] status, [23:18] header_total
    output logic [2:0]  m_axis_tuser,  // [2:0] byte_class
    output logic        m_axis_tlast   // done_res
);

    localparam int FLEN_W = hrht_pkg::FLEN_W;
    localparam int HCNT_W = hrht_pkg::HCNT_W;

    typedef enum logic [2:0] {
        PH_METHOD,
        PH_PATH,
        PH_VERSION,
        PH_LINE,
        PH_NAME,
        PH_VALUE,
        PH_BODY,
        PH_ERROR
    } phase_t;

    phase_t                phase_reg, phase_next;
    logic [FLEN_W-1:0]     flen_reg, flen_next, flen_inc;
    logic [FLEN_W:0]       flen_plus1;
    logic [HCNT_W-1:0]     hcnt_reg, hcnt_next;
    logic                  cr_reg, cr_next;
    logic                  vb_reg, vb_next;
    hrht_pkg::status_t     ec_reg, ec_next, code, end_code;

    hrht_pkg::byte_class_t cls;
    logic                  fs, en, lone, s_xfer;
    hrht_pkg::status_t     st;
    logic [7:0]            b;

    logic [7:0]            out_byte_reg;
    logic [2:0]            cls_out_reg;
    logic [4:0]            idx_out_reg;
    logic                  fs_out_reg, en_out_reg, done_out_reg, m_valid_reg;
    logic [2:0]            st_out_reg;
    logic [5:0]            total_out_reg;

    assign b             = s_axis_tdata;
    assign s_axis_tready = !m_valid_reg || m_axis_tready;
    assign s_xfer        = s_axis_tvalid && s_axis_tready;

    assign flen_plus1 = {1'b0, flen_reg} + {{FLEN_W{1'b0}}, 1'b1};
    assign flen_inc   = (&flen_reg) ? flen_reg : flen_plus1[FLEN_W-1:0];

    always_comb begin
        phase_next = phase_reg;
        flen_next  = flen_reg;
        hcnt_next  = hcnt_reg;
        cr_next    = cr_reg;
        vb_next    = vb_reg;
        ec_next    = ec_reg;
        code       = hrht_pkg::ST_OK;
        end_code   = hrht_pkg::ST_OK;
        cls        = hrht_pkg::CLS_SEP;
        fs         = 1'b0;
        en         = 1'b0;
        st         = hrht_pkg::ST_OK;
        lone       = (phase_reg == PH_LINE) && !cr_reg && s_axis_tlast;

        unique case (phase_reg)
            PH_METHOD: begin
                if (b == hrht_pkg::CH_SP) begin
                    phase_next = PH_PATH;
                    flen_next  = '0;
                end else if (flen_plus1 >= (FLEN_W+1)'(hrht_pkg::METHOD_LIMIT)) begin
                    code = hrht_pkg::ST_METHOD_LONG;
                end else begin
                    cls       = hrht_pkg::CLS_METHOD;
                    fs        = (flen_reg == '0);
                    flen_next = flen_inc;
                end
            end
            PH_PATH: begin
                if (b == hrht_pkg::CH_SP) begin
                    phase_next = PH_VERSION;
                    flen_next  = '0;
                end else if (flen_plus1 >= (FLEN_W+1)'(hrht_pkg::PATH_LIMIT)) begin
                    code = hrht_pkg::ST_PATH_LONG;
                end else begin
                    cls       = hrht_pkg::CLS_PATH;
                    fs        = (flen_reg == '0);
                    flen_next = flen_inc;
                end
            end
            PH_VERSION: begin
                if (cr_reg) begin
                    if (b == hrht_pkg::CH_LF) begin
                        cr_next    = 1'b0;
                        phase_next = PH_LINE;
                        flen_next  = '0;
                    end else begin
                        code = hrht_pkg::ST_BAD_EOL;
                    end
                end else if (b == hrht_pkg::CH_CR) begin
                    cr_next = 1'b1;
                end else begin
                    cls       = hrht_pkg::CLS_VERSION;
                    fs        = (flen_reg == '0);
                    flen_next = flen_inc;
                end
            end
            PH_LINE: begin
                if (cr_reg) begin
                    if (b == hrht_pkg::CH_LF) begin
                        cr_next    = 1'b0;
                        phase_next = PH_BODY;
                        flen_next  = '0;
                    end else begin
                        code = hrht_pkg::ST_BAD_EOL;
                    end
                end else if (b == hrht_pkg::CH_CR) begin
                    cr_next = 1'b1;
                end else if (lone) begin
                    cls        = hrht_pkg::CLS_NAME;
                    fs         = 1'b1;
                    phase_next = PH_NAME;
                    flen_next  = FLEN_W'(1);
                end else if (hcnt_reg >= HCNT_W'(hrht_pkg::HEADER_LIMIT)) begin
                    code = hrht_pkg::ST_TOO_MANY;
                end else if (b == hrht_pkg::CH_LF) begin
                    code = hrht_pkg::ST_NO_COLON;
                end else if (b == hrht_pkg::CH_COLON) begin
                    phase_next = PH_VALUE;
                    vb_next    = 1'b0;
                    flen_next  = '0;
                end else begin
                    cls        = hrht_pkg::CLS_NAME;
                    fs         = 1'b1;
                    phase_next = PH_NAME;
                    flen_next  = FLEN_W'(1);
                end
            end
            PH_NAME: begin
                if (b == hrht_pkg::CH_COLON) begin
                    phase_next = PH_VALUE;
                    vb_next    = 1'b0;
                    flen_next  = '0;
                end else if (b == hrht_pkg::CH_CR || b == hrht_pkg::CH_LF) begin
                    code = hrht_pkg::ST_NO_COLON;
                end else begin
                    cls       = hrht_pkg::CLS_NAME;
                    flen_next = flen_inc;
                end
            end
            PH_VALUE: begin
                if (cr_reg) begin
                    if (b == hrht_pkg::CH_LF) begin
                        cr_next    = 1'b0;
                        hcnt_next  = (&hcnt_reg) ? hcnt_reg : hcnt_reg + HCNT_W'(1);
                        phase_next = PH_LINE;
                        flen_next  = '0;
                        vb_next    = 1'b0;
                    end else begin
                        code = hrht_pkg::ST_BAD_EOL;
                    end
                end else if (b == hrht_pkg::CH_CR) begin
                    cr_next = 1'b1;
                end else if (!vb_reg && (b == hrht_pkg::CH_SP || b == hrht_pkg::CH_TAB)) begin
                    // leading whitespace of a value is dropped
                end else begin
                    cls       = hrht_pkg::CLS_VALUE;
                    fs        = !vb_reg;
                    vb_next   = 1'b1;
                    flen_next = flen_inc;
                end
            end
            PH_BODY: begin
                cls       = hrht_pkg::CLS_BODY;
                fs        = (flen_reg == '0);
                flen_next = flen_inc;
            end
            default: begin
            end
        endcase

        if (code != hrht_pkg::ST_OK) begin
            ec_next    = code;
            phase_next = PH_ERROR;
            en         = 1'b1;
            cls        = hrht_pkg::CLS_SEP;
            fs         = 1'b0;
        end

        if (s_axis_tlast) begin
            if (phase_next != PH_ERROR && !lone) begin
                if (phase_next == PH_METHOD || phase_next == PH_PATH) begin
                    end_code = hrht_pkg::ST_NO_SPACE;
                end else if (phase_next == PH_NAME) begin
                    end_code = hrht_pkg::ST_NO_COLON;
                end else if (phase_next == PH_VERSION || phase_next == PH_VALUE || cr_next) begin
                    end_code = hrht_pkg::ST_BAD_EOL;
                end
                if (end_code != hrht_pkg::ST_OK) begin
                    ec_next = end_code;
                    en      = 1'b1;
                end
            end
            st = ec_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_METHOD;
            flen_reg    <= '0;
            hcnt_reg    <= '0;
            cr_reg      <= 1'b0;
            vb_reg      <= 1'b0;
            ec_reg      <= hrht_pkg::ST_OK;
            m_valid_reg <= 1'b0;
        end else begin
            if (s_xfer) begin
                if (s_axis_tlast) begin
                    phase_reg <= PH_METHOD;
                    flen_reg  <= '0;
                    hcnt_reg  <= '0;
                    cr_reg    <= 1'b0;
                    vb_reg    <= 1'b0;
                    ec_reg    <= hrht_pkg::ST_OK;
                end else begin
                    phase_reg <= phase_next;
                    flen_reg  <= flen_next;
                    hcnt_reg  <= hcnt_next;
                    cr_reg    <= cr_next;
                    vb_reg    <= vb_next;
                    ec_reg    <= ec_next;
                end
                out_byte_reg  <= b;
                cls_out_reg   <= cls;
                idx_out_reg   <= hcnt_reg[4:0];
                fs_out_reg    <= fs;
                en_out_reg    <= en;
                done_out_reg  <= s_axis_tlast;
                st_out_reg    <= st;
                total_out_reg <= 6'(hcnt_next);
                m_valid_reg   <= 1'b1;
            end else if (m_axis_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {total_out_reg, st_out_reg, en_out_reg, fs_out_reg,
                            idx_out_reg, out_byte_reg};
    assign m_axis_tuser  = cls_out_reg;
    assign m_axis_tlast  = done_out_reg;

    `HRHT_ASSERT(a_status_only_on_last,
        m_valid_reg && !done_out_reg |-> st_out_reg == 3'(hrht_pkg::ST_OK),
        "status set on a byte that is not the last")
    `HRHT_ASSERT(a_error_byte_dropped,
        m_valid_reg && en_out_reg && !done_out_reg |-> cls_out_reg == 3'(hrht_pkg::CLS_SEP),
        "error byte not tagged as separator")
    `HRHT_ASSERT(a_error_phase_has_code,
        phase_reg == PH_ERROR |-> ec_reg != hrht_pkg::ST_OK,
        "error phase without an error code")
    `HRHT_ASSERT(a_last_restarts_parse,
        s_xfer && s_axis_tlast |=> phase_reg == PH_METHOD && hcnt_reg == '0 && !cr_reg,
        "parse state not restarted after last byte")

endmodule
`default_nettype wire
